// ===== rtl/core/dit_pkg.sv =====
// Shared types and constants for the dual interval timer unit.
// Depends on nothing; used by dit_timer and dual_interval_timer_unit.
`timescale 1ns / 1ps

package dit_pkg;

  // Item kinds carried in the action field. Code three is unused and changes nothing.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } dit_action_e;

  // Register numbers within one timer unit.
  localparam logic [3:0] REG_TA_LO = 4'd4;
  localparam logic [3:0] REG_TA_HI = 4'd5;
  localparam logic [3:0] REG_TB_LO = 4'd6;
  localparam logic [3:0] REG_TB_HI = 4'd7;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  // Control register bits.
  localparam int unsigned CTL_EN_BIT      = 0;
  localparam int unsigned CTL_ONESHOT_BIT = 3;
  localparam int unsigned CTL_LOAD_BIT    = 4;
  localparam int unsigned CTL_ASRC_BIT    = 5;

  // Timer B count source codes (control bits 6:5).
  localparam logic [1:0] BSRC_TICK = 2'b00;
  localparam logic [1:0] BSRC_TA   = 2'b10;

  // Interrupt register layout.
  localparam int unsigned FLAG_W      = 5;
  localparam int unsigned FLAG_TA_BIT = 0;
  localparam int unsigned FLAG_TB_BIT = 1;
  localparam int unsigned ICR_SET_BIT = 7;

  // One decoded item as seen by a single timer unit.
  typedef struct packed {
    logic       tick;
    logic       rd;
    logic       wr;
    logic [3:0] addr;
    logic [7:0] wdata;
  } dit_req_t;

  // Input item fields held in the input register.
  typedef struct packed {
    logic [7:0] write_data;
    logic [3:0] reg_addr;
    logic       unit;
    logic [1:0] action;
  } dit_item_t;

endpackage

// ===== rtl/core/dit_timer.sv =====
// One timer unit: sixteen byte registers, timers A and B with reload latches,
// interrupt flags and mask. Depends on dit_pkg.
`timescale 1ns / 1ps

module dit_timer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dit_pkg::dit_req_t req_i,
  output logic [7:0]        rdata_o,
  output logic              line_o
);

  logic [7:0]  regs_q [16];
  logic [7:0]  regs_d [16];
  logic [15:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [15:0] latch_a_q, latch_a_d, latch_b_q, latch_b_d;
  logic [dit_pkg::FLAG_W-1:0] flags_q, flags_d, mask_q, mask_d;

  logic [7:0]  ctl_a, ctl_b;
  logic [15:0] a_dec, b_dec;
  logic        a_run, a_under, b_run;
  logic [7:0]  wval;

  assign ctl_a   = regs_q[dit_pkg::REG_CRA];
  assign ctl_b   = regs_q[dit_pkg::REG_CRB];
  assign a_dec   = cnt_a_q - 16'd1;
  assign b_dec   = cnt_b_q - 16'd1;
  assign a_run   = ctl_a[dit_pkg::CTL_EN_BIT] && !ctl_a[dit_pkg::CTL_ASRC_BIT];
  assign a_under = a_run && (a_dec == 16'd0);
  assign b_run   = ctl_b[dit_pkg::CTL_EN_BIT] &&
                   ((ctl_b[6:5] == dit_pkg::BSRC_TICK) ||
                    ((ctl_b[6:5] == dit_pkg::BSRC_TA) && a_under));

  always_comb begin
    regs_d    = regs_q;
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    latch_a_d = latch_a_q;
    latch_b_d = latch_b_q;
    flags_d   = flags_q;
    mask_d    = mask_q;
    rdata_o   = 8'd0;
    wval      = req_i.wdata;

    if (req_i.tick) begin
      if (a_run) begin
        cnt_a_d = a_dec;
        if (a_under) begin
          flags_d[dit_pkg::FLAG_TA_BIT] = 1'b1;
          if (ctl_a[dit_pkg::CTL_ONESHOT_BIT]) begin
            regs_d[dit_pkg::REG_CRA][dit_pkg::CTL_EN_BIT] = 1'b0;
          end
          cnt_a_d = latch_a_q;
        end
      end
      if (b_run) begin
        cnt_b_d = b_dec;
        if (b_dec == 16'd0) begin
          flags_d[dit_pkg::FLAG_TB_BIT] = 1'b1;
          if (ctl_b[dit_pkg::CTL_ONESHOT_BIT]) begin
            regs_d[dit_pkg::REG_CRB][dit_pkg::CTL_EN_BIT] = 1'b0;
          end
          cnt_b_d = latch_b_q;
        end
      end
    end

    if (req_i.rd) begin
      unique case (req_i.addr)
        dit_pkg::REG_TA_LO: rdata_o = cnt_a_q[7:0];
        dit_pkg::REG_TA_HI: rdata_o = cnt_a_q[15:8];
        dit_pkg::REG_TB_LO: rdata_o = cnt_b_q[7:0];
        dit_pkg::REG_TB_HI: rdata_o = cnt_b_q[15:8];
        dit_pkg::REG_ICR: begin
          rdata_o = {|(flags_q & mask_q), 2'b00, flags_q};
          flags_d = '0;
        end
        default: rdata_o = regs_q[req_i.addr];
      endcase
    end

    if (req_i.wr) begin
      unique case (req_i.addr)
        dit_pkg::REG_TA_LO: latch_a_d[7:0]  = req_i.wdata;
        dit_pkg::REG_TA_HI: latch_a_d[15:8] = req_i.wdata;
        dit_pkg::REG_TB_LO: latch_b_d[7:0]  = req_i.wdata;
        dit_pkg::REG_TB_HI: latch_b_d[15:8] = req_i.wdata;
        dit_pkg::REG_ICR: begin
          if (req_i.wdata[dit_pkg::ICR_SET_BIT]) begin
            mask_d = mask_q | req_i.wdata[dit_pkg::FLAG_W-1:0];
          end else begin
            mask_d = mask_q & ~req_i.wdata[dit_pkg::FLAG_W-1:0];
          end
        end
        dit_pkg::REG_CRA: begin
          if (req_i.wdata[dit_pkg::CTL_LOAD_BIT]) begin
            cnt_a_d = latch_a_q;
            wval[dit_pkg::CTL_LOAD_BIT] = 1'b0;
          end
        end
        dit_pkg::REG_CRB: begin
          if (req_i.wdata[dit_pkg::CTL_LOAD_BIT]) begin
            cnt_b_d = latch_b_q;
            wval[dit_pkg::CTL_LOAD_BIT] = 1'b0;
          end
        end
        default: ;
      endcase
      regs_d[req_i.addr] = wval;
    end
  end

  // Interrupt line as it stands after the current item.
  assign line_o = |(flags_d & mask_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        regs_q[i] <= 8'd0;
      end
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      latch_a_q <= '0;
      latch_b_q <= '0;
      flags_q   <= '0;
      mask_q    <= '0;
    end else begin
      regs_q    <= regs_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      latch_a_q <= latch_a_d;
      latch_b_q <= latch_b_d;
      flags_q   <= flags_d;
      mask_q    <= mask_d;
    end
  end

endmodule

// ===== rtl/core/dual_interval_timer_unit.sv =====
// Top level of the dual interval timer unit: input register, two timer units
// and the result register. Depends on dit_pkg and dit_timer.
`timescale 1ns / 1ps

// Usage:
// The block holds two timer units, unit 0 and unit 1, each with sixteen byte
// registers, two 16-bit down counters with reload latches and an interrupt
// flag/mask pair. Every transfer on the slave stream is one item: a tick that
// steps both units, a register read, or a register write. For every item the
// master stream delivers exactly one result carrying the read byte (zero for
// ticks and writes) and the irq and nmi levels as they stand after the item.
// An accepted item sits in the input register, where the unit logic works on
// it against the current state; when it advances, the state is updated and
// the result is registered together. One item per cycle is sustained while
// the receiver keeps up: the input register frees itself whenever the
// result register is empty or being emptied.
// If the receiver stalls, the result register holds its transfer and the
// input register holds at most one further item, then tready drops.
// Reset clears all registers, counters, latches, flags and masks to zero and
// empties both pipeline registers.

module dual_interval_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: action[1:0], unit[2], reg_addr[6:3],
  // write_data[14:7], zero pad[15].
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: read_data[7:0], irq_line[8], nmi_line[9],
  // zero pad[15:10].
  output logic [15:0] m_axis_tdata
);

  dit_pkg::dit_item_t item_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;
  logic               advance;

  logic               is_tick, is_read, is_write;
  dit_pkg::dit_req_t  req [2];
  logic [7:0]         rdata [2];
  logic [1:0]         line;
  logic [7:0]         read_data;

  // The item in the input register completes when the result slot is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= s_axis_tdata[14:0];
    end
  end

  // Decode the item kind; code three does nothing.
  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (item_q.action)
      dit_pkg::ACT_TICK:  is_tick  = 1'b1;
      dit_pkg::ACT_READ:  is_read  = 1'b1;
      dit_pkg::ACT_WRITE: is_write = 1'b1;
      default: ;
    endcase
  end

  for (genvar u = 0; u < 2; u++) begin : g_unit
    logic sel;
    assign sel = (item_q.unit == 1'(u));
    assign req[u].tick  = advance && is_tick;
    assign req[u].rd    = advance && is_read && sel;
    assign req[u].wr    = advance && is_write && sel;
    assign req[u].addr  = item_q.reg_addr;
    assign req[u].wdata = item_q.write_data;

    dit_timer u_timer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req[u]),
      .rdata_o (rdata[u]),
      .line_o  (line[u])
    );
  end

  // Only the addressed unit drives a nonzero byte.
  assign read_data = rdata[0] | rdata[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, line[1], line[0], read_data};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A stalled result keeps a waiting item in the input register.
  a_hold_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && in_valid_q) |=> in_valid_q)
    else $error("input item lost while result stalled");

  // Only reads return a nonzero byte.
  a_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_read) |=> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero read_data on a non-read item");

  // Reading the interrupt register of unit 0 clears its flags, so irq drops.
  a_icr_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_read && !item_q.unit && item_q.reg_addr == dit_pkg::REG_ICR)
      |=> !m_axis_tdata[8])
    else $error("irq still high after interrupt register read");

endmodule
